// ===== rtl/spq_pkg.sv =====
// shared types and codes of the scan priority queue
// depends on nothing, used by spq_cell, scan_priority_queue and the bench
package spq_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } spq_state_e;

  // input command codes, carried in the slave tuser bit
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // order mode codes
  localparam logic ORDER_MAX_FIRST = 1'b0;
  localparam logic ORDER_MIN_FIRST = 1'b1;

  typedef struct packed {
    logic shift;  // take the entry of the right-hand neighbor
    logic load;   // take the write data
  } spq_cell_ctrl_t;

endpackage

// ===== rtl/scan_priority_queue.sv =====
// scan priority queue top level: ring of entry cells plus scan controller
// depends on spq_pkg and spq_cell
// timing: an insert, or a remove on empty, goes from IDLE through DONE into the output
//   register; any other remove first scans, the ring rotating once through all DEPTH cells
// flow: one item at a time, the next accepted the cycle after the result is registered;
//   a held result stalls the controller in DONE until the output register frees up
// reset: entry count, order mode and output valid clear; stored entries are
//   left as they are, only occupied entries are ever read
module scan_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH         = 64,
  parameter int unsigned KEY_WIDTH     = 16,
  parameter int unsigned PAYLOAD_WIDTH = 32,
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1),
  localparam int unsigned IN_DATA_W    = ((KEY_WIDTH + PAYLOAD_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_DATA_W   = ((KEY_WIDTH + PAYLOAD_WIDTH + CNT_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration: order mode, 0 largest key first, 1 smallest first
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // key, payload, zero pad
  input  logic                  s_axis_tuser,   // command
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_key, out_payload, occupancy, zero pad
  output logic [1:0]            m_axis_tuser    // status
);

  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned ENTRY_W = KEY_WIDTH + PAYLOAD_WIDTH;

  // ---------------------------------------------------------------------------
  // control and latched item
  // ---------------------------------------------------------------------------
  spq_state_e state_q, state_d;

  logic                 order_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [IDX_W-1:0]     scan_idx_q, scan_idx_d;

  logic                 cmd_q;
  logic [ENTRY_W-1:0]   item_q;           // {payload, key} of the accepted beat

  // running winner of the scan and a copy of the last occupied entry
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  logic [ENTRY_W-1:0]   best_q, best_d;
  logic [ENTRY_W-1:0]   last_q, last_d;

  // output register
  logic                 m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic [1:0]           m_user_q, m_user_d;

  // ring write port
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [ENTRY_W-1:0]   wr_data;
  logic                 ring_shift;

  // ---------------------------------------------------------------------------
  // entry ring: cell i takes cell i+1, the last cell takes cell 0, so after
  // DEPTH shifts every entry is back in its own cell
  // ---------------------------------------------------------------------------
  logic [ENTRY_W-1:0]   cell_data [DEPTH];

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    localparam int unsigned NEXT = (gi + 1) % DEPTH;
    spq_cell_ctrl_t cell_ctrl;

    assign cell_ctrl.shift = ring_shift;
    assign cell_ctrl.load  = wr_en && (wr_addr == IDX_W'(gi));

    spq_cell #(
      .ENTRY_W (ENTRY_W)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .shift_data_i (cell_data[NEXT]),
      .load_data_i  (wr_data),
      .data_o       (cell_data[gi])
    );
  end

  // head of the ring: during scan step k it holds the entry of index k
  logic [ENTRY_W-1:0]   head;
  logic [KEY_WIDTH-1:0] head_key;
  logic [KEY_WIDTH-1:0] best_key;
  logic                 head_beats;
  logic [CNT_W-1:0]     scan_pos;
  logic                 scan_occupied;
  logic                 scan_is_last;

  assign head          = cell_data[0];
  assign head_key      = head[KEY_WIDTH-1:0];
  assign best_key      = best_q[KEY_WIDTH-1:0];
  // strict compare keeps the lowest index on ties
  assign head_beats    = (order_q == ORDER_MAX_FIRST) ? (head_key > best_key)
                                                      : (head_key < best_key);
  assign scan_pos      = CNT_W'(scan_idx_q);
  assign scan_occupied = scan_pos < count_q;
  assign scan_is_last  = scan_pos == (count_q - CNT_W'(1));

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready;

  // ---------------------------------------------------------------------------
  // next state and datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_idx_d = scan_idx_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    last_d     = last_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;
    wr_en      = 1'b0;
    wr_addr    = count_q[IDX_W-1:0];
    wr_data    = item_q;
    ring_shift = 1'b0;
    s_axis_tready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        scan_idx_d    = '0;
        if (s_axis_tvalid) begin
          if ((s_axis_tuser == CMD_REMOVE) && (count_q != '0)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_SCAN: begin
        ring_shift = 1'b1;
        if (scan_occupied) begin
          if ((scan_idx_q == '0) || head_beats) begin
            best_idx_d = scan_idx_q;
            best_d     = head;
          end
          if (scan_is_last) begin
            last_d = head;
          end
        end
        scan_idx_d = scan_idx_q + IDX_W'(1);
        if (scan_idx_q == IDX_W'(DEPTH - 1)) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          state_d   = ST_IDLE;
          m_valid_d = 1'b1;
          if (cmd_q == CMD_INSERT) begin
            if (count_q == CNT_W'(DEPTH)) begin
              m_user_d = STATUS_FULL;
            end else begin
              wr_en    = 1'b1;
              count_d  = count_q + CNT_W'(1);
              m_user_d = STATUS_DONE;
            end
            m_data_d = OUT_DATA_W'({count_d, {ENTRY_W{1'b0}}});
          end else if (count_q == '0) begin
            m_user_d = STATUS_EMPTY;
            m_data_d = OUT_DATA_W'({count_q, {ENTRY_W{1'b0}}});
          end else begin
            // fill the hole with the last entry, the last occupied cell falls out
            wr_en    = 1'b1;
            wr_addr  = best_idx_q;
            wr_data  = last_q;
            count_d  = count_q - CNT_W'(1);
            m_user_d = STATUS_DONE;
            m_data_d = OUT_DATA_W'({count_d, best_q});
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      order_q   <= ORDER_MAX_FIRST;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    scan_idx_q <= scan_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    last_q     <= last_d;
    m_data_q   <= m_data_d;
    m_user_q   <= m_user_d;
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q  <= s_axis_tuser;
      item_q <= s_axis_tdata[ENTRY_W-1:0];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ===== rtl/spq_cell.sv =====
// one storage cell of the entry ring: holds one key and payload entry
// depends on spq_pkg for the cell control struct
module spq_cell import spq_pkg::*; #(
  parameter int unsigned ENTRY_W = 48
) (
  input  logic               clk_i,
  input  spq_cell_ctrl_t     ctrl_i,
  input  logic [ENTRY_W-1:0] shift_data_i,
  input  logic [ENTRY_W-1:0] load_data_i,
  output logic [ENTRY_W-1:0] data_o
);

  logic [ENTRY_W-1:0] entry_q;
  logic [ENTRY_W-1:0] entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = load_data_i;
    end else if (ctrl_i.shift) begin
      entry_d = shift_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign data_o = entry_q;

endmodule

// ===== bench/tb_scan_priority_queue.sv =====
// self-checking bench for scan_priority_queue: random and directed insert/remove beats,
// result beats checked against a shadow unsorted-array queue kept in the bench
// depends on spq_pkg and the scan_priority_queue rtl
module tb_scan_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int DEPTH  = 64;
  localparam int KEY_W  = 16;
  localparam int PAY_W  = 32;
  localparam int CNT_W  = 7;
  localparam int IN_W   = 48;
  localparam int OUT_W  = 56;
  localparam int PAD_LO = KEY_W + PAY_W + CNT_W;

  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } queue_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [1:0]       status;
    logic [CNT_W-1:0] occupancy;
  } queue_result_t;

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic             cfg_wdata_i   = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;  // key, payload
  logic             s_axis_tuser  = 1'b0; // command
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;        // out_key, out_payload, occupancy, pad
  logic [1:0]       m_axis_tuser;        // status

  scan_priority_queue #(
    .DEPTH        (DEPTH),
    .KEY_WIDTH    (KEY_W),
    .PAYLOAD_WIDTH(PAY_W)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // shadow copy of the queue contents and the order register
  logic [KEY_W-1:0] shadow_key     [DEPTH];
  logic [PAY_W-1:0] shadow_payload [DEPTH];
  int               shadow_count = 0;
  logic             order_sel    = ORDER_MAX_FIRST;

  queue_item_t   items_to_send[$];
  queue_result_t awaited_results[$];
  queue_item_t   in_flight;

  int send_idle_pct  = 0;  // chance the sender holds off a beat
  int recv_stall_pct = 0;  // chance the receiver drops tready
  int fail_count     = 0;
  int gen_count      = 0;  // occupancy as the stimulus generator sees it

  // apply one command to the shadow queue and return the result beat it should give
  function automatic queue_result_t apply_queue_op(queue_item_t it);
    queue_result_t r;
    int            best;
    int            last;
    r        = '0;
    r.status = STATUS_DONE;
    if (it.cmd == CMD_INSERT) begin
      if (shadow_count >= DEPTH) begin
        r.status = STATUS_FULL;  // dropped, nothing changes
      end else begin
        shadow_key[shadow_count]     = it.key;
        shadow_payload[shadow_count] = it.payload;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      // first entry of strictly highest priority wins, so ties keep the lowest index
      best = 0;
      for (int i = 1; i < shadow_count; i++) begin
        if (order_sel == ORDER_MAX_FIRST ? shadow_key[i] > shadow_key[best]
                                         : shadow_key[i] < shadow_key[best]) begin
          best = i;
        end
      end
      r.key     = shadow_key[best];
      r.payload = shadow_payload[best];
      // last entry fills the hole
      last                 = shadow_count - 1;
      shadow_key[best]     = shadow_key[last];
      shadow_payload[best] = shadow_payload[last];
      shadow_count         = last;
    end
    r.occupancy = CNT_W'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // driver: on an accepted beat record its outcome, then present the next item
  // tvalid stays high back to back unless the sender holds off or runs dry; one assignment per edge
  always @(posedge clk_i) begin : drive_items
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(apply_queue_op(in_flight));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (items_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_flight = items_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {in_flight.payload, in_flight.key};
          s_axis_tuser  <= in_flight.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest outstanding outcome
  always @(posedge clk_i) begin : check_results
    queue_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", m_axis_tdata, 0);
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tdata[KEY_W-1:0] !== want.key)
          report_mismatch("out_key", m_axis_tdata[KEY_W-1:0], want.key);
        if (m_axis_tdata[KEY_W+PAY_W-1:KEY_W] !== want.payload)
          report_mismatch("out_payload", m_axis_tdata[KEY_W+PAY_W-1:KEY_W], want.payload);
        if (m_axis_tdata[PAD_LO-1:KEY_W+PAY_W] !== want.occupancy)
          report_mismatch("occupancy", m_axis_tdata[PAD_LO-1:KEY_W+PAY_W], want.occupancy);
        if (m_axis_tdata[OUT_W-1:PAD_LO] !== '0)
          report_mismatch("tdata pad", m_axis_tdata[OUT_W-1:PAD_LO], 0);
        if (m_axis_tuser !== want.status)
          report_mismatch("status", m_axis_tuser, want.status);
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // key mix: full range, tight clusters for ties, and both extremes
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0:       return KEY_W'($urandom);
      1:       return KEY_W'($urandom_range(0, 7));
      2:       return $urandom_range(0, 1) ? '1 : '0;
      default: return KEY_W'($urandom_range(16'hfff8, 16'hffff));
    endcase
  endfunction

  task automatic queue_item(logic cmd, logic [KEY_W-1:0] key, logic [PAY_W-1:0] payload);
    queue_item_t it;
    it.cmd     = cmd;
    it.key     = key;
    it.payload = payload;
    items_to_send.push_back(it);
    if (cmd == CMD_INSERT && gen_count < DEPTH) gen_count++;
    if (cmd == CMD_REMOVE && gen_count > 0) gen_count--;
  endtask

  // fill to full, push a few dropped inserts, drain to empty, then remove on empty
  task automatic queue_fill_cycle();
    while (gen_count < DEPTH) queue_item(CMD_INSERT, pick_key(), $urandom);
    repeat ($urandom_range(1, 3)) queue_item(CMD_INSERT, pick_key(), $urandom);
    while (gen_count > 0) queue_item(CMD_REMOVE, KEY_W'($urandom), $urandom);
    repeat ($urandom_range(1, 2)) queue_item(CMD_REMOVE, KEY_W'($urandom), $urandom);
  endtask

  // runs of insert-heavy, balanced and remove-heavy traffic
  task automatic queue_mixed(int n);
    int ins_pct;
    ins_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) ins_pct = 20 + 30 * $urandom_range(0, 2);
      if ($urandom_range(0, 99) < ins_pct) queue_item(CMD_INSERT, pick_key(), $urandom);
      else queue_item(CMD_REMOVE, KEY_W'($urandom), $urandom);
    end
  endtask

  // let the backlog go out and every result come back
  task automatic drain_all();
    while (items_to_send.size() > 0 || s_axis_tvalid || awaited_results.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // order register may only change with the queue idle
  task automatic write_order(logic mode);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    order_sel = mode;
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 6;
    recv_stall_pct = 70;

    // largest first: empty remove, extremes, a tie on the top key
    write_order(ORDER_MAX_FIRST);
    queue_item(CMD_REMOVE, '0, '0);
    queue_item(CMD_INSERT, 16'h0000, 32'h0000_0000);
    queue_item(CMD_INSERT, 16'hffff, 32'hffff_ffff);
    queue_item(CMD_INSERT, 16'hffff, 32'h5a5a_5a5a);
    queue_item(CMD_INSERT, 16'h8000, 32'h8000_0001);
    repeat (5) queue_item(CMD_REMOVE, '1, '1);
    drain_all();

    // smallest first: tie on zero, a moved last entry wins next
    write_order(ORDER_MIN_FIRST);
    queue_item(CMD_INSERT, 16'h0005, 32'ha5a5_a5a5);
    queue_item(CMD_INSERT, 16'h0000, 32'h1111_1111);
    queue_item(CMD_INSERT, 16'hffff, 32'h2222_2222);
    queue_item(CMD_INSERT, 16'h0000, 32'h3333_3333);
    repeat (3) queue_item(CMD_REMOVE, '0, '0);
    queue_item(CMD_INSERT, 16'h7fff, 32'hcccc_cccc);
    repeat (3) queue_item(CMD_REMOVE, '0, '0);
    drain_all();

    // random phases: order toggles, idling moves from receiver to sender to none
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct  = (ph < 2) ? 6 : (ph < 4) ? 70 : 0;
      recv_stall_pct = (ph < 2) ? 70 : (ph < 4) ? 6 : 0;
      write_order(ph % 2 == 0 ? ORDER_MAX_FIRST : ORDER_MIN_FIRST);
      queue_fill_cycle();
      queue_mixed(120);
      drain_all();
    end

    // catch any stray result beat
    repeat (DEPTH + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
